// ----- hdl/prao_pkg.sv -----
// shared constants and types for the point rotation block
// no dependencies; imported by every module under hdl
package prao_pkg;

  localparam int GUARD_BITS = 8;
  localparam int ANGLE_W    = 32;
  localparam int TABLE_SIZE = 32;

  // low part width of the gain multiply, the product is rounded at this bit
  localparam int SPLIT = ANGLE_W - GUARD_BITS;

  // reciprocal of the cordic gain, q0.32
  localparam logic [31:0] INV_GAIN = 32'd2608131496;

  // atan(2^-i) as a fraction of a full turn, 2^32 per turn
  localparam logic [ANGLE_W-1:0] ATAN_TURNS [TABLE_SIZE] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [1:0]                quad_t;
  typedef logic [1:0]                reg_index_t;

  // configuration register indexes
  localparam reg_index_t REG_CENTRE_X  = 2'd0;
  localparam reg_index_t REG_CENTRE_Y  = 2'd1;
  localparam reg_index_t REG_TURN      = 2'd2;
  localparam reg_index_t REG_CLOCKWISE = 2'd3;

endpackage

// ----- hdl/prao_prescale.sv -----
// offset from centre, gain prescale and quarter-turn for both coordinates
// five register stages; uses prao_pkg
module prao_prescale #(
  parameter int COORD_WIDTH = 32,
  parameter int WORK_WIDTH  = 43
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] centre_x,
  input  logic signed [COORD_WIDTH-1:0] centre_y,
  input  prao_pkg::quad_t               quad,
  output logic                          out_valid,
  output logic signed [WORK_WIDTH-1:0]  x,
  output logic signed [WORK_WIDTH-1:0]  y
);
  import prao_pkg::*;

  localparam int DW  = COORD_WIDTH + 1;
  localparam int AW  = (DW > SPLIT + 1) ? DW : SPLIT + 1;
  localparam int PHW = AW - SPLIT + 32;
  localparam int PLW = SPLIT + 32;
  localparam int SW  = AW + 9;
  localparam int MW  = COORD_WIDTH + GUARD_BITS;
  localparam logic [PLW:0] HALF = (PLW + 1)'(1) << (SPLIT - 1);

  logic [4:0]            vld;
  logic signed [DW-1:0]  d    [2];
  logic [AW-1:0]         mag  [2];
  logic                  neg1 [2];
  logic [PHW-1:0]        ph   [2];
  logic [PLW-1:0]        pl   [2];
  logic                  neg2 [2];
  logic [MW-1:0]         vm   [2];
  logic                  neg3 [2];

  logic [DW-1:0]         abs_d [2];
  logic [PLW:0]          rl    [2];
  logic [SW-1:0]         vsum  [2];
  logic [MW-1:0]         x_src, y_src;
  logic                  x_neg, y_neg;
  logic signed [WORK_WIDTH-1:0] x_ext, y_ext;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      abs_d[k] = d[k][DW-1] ? (~d[k] + 1'b1) : d[k];
      rl[k]    = (PLW + 1)'(pl[k]) + HALF;
      vsum[k]  = SW'(ph[k]) + SW'(rl[k][PLW:SPLIT]);
    end
    // quarter turn: swap on odd quadrants, sign flips folded into one negate
    x_src = quad[0] ? vm[1] : vm[0];
    y_src = quad[0] ? vm[0] : vm[1];
    x_neg = (quad[0] ? neg3[1] : neg3[0]) ^ quad[1] ^ quad[0];
    y_neg = (quad[0] ? neg3[0] : neg3[1]) ^ quad[1];
    x_ext = WORK_WIDTH'(x_src);
    y_ext = WORK_WIDTH'(y_src);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d[0] <= DW'(point_x) - DW'(centre_x);
      d[1] <= DW'(point_y) - DW'(centre_y);
      for (int k = 0; k < 2; k++) begin
        neg1[k] <= d[k][DW-1];
        mag[k]  <= AW'(abs_d[k]);
        neg2[k] <= neg1[k];
        ph[k]   <= PHW'(mag[k][AW-1:SPLIT]) * PHW'(INV_GAIN);
        pl[k]   <= PLW'(mag[k][SPLIT-1:0]) * PLW'(INV_GAIN);
        neg3[k] <= neg2[k];
        vm[k]   <= vsum[k][MW-1:0];
      end
      x <= x_neg ? -x_ext : x_ext;
      y <= y_neg ? -y_ext : y_ext;
    end
  end

  assign out_valid = vld[4];

endmodule

// ----- hdl/prao_cell.sv -----
// one shift-add micro-rotation of the cordic chain
// uses prao_pkg for the arctangent table
module prao_cell #(
  parameter int WORK_WIDTH = 43,
  parameter int STAGE      = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [WORK_WIDTH-1:0] x_in,
  input  logic signed [WORK_WIDTH-1:0] y_in,
  input  prao_pkg::angle_t             r_in,
  output logic                         out_valid,
  output logic signed [WORK_WIDTH-1:0] x_out,
  output logic signed [WORK_WIDTH-1:0] y_out,
  output prao_pkg::angle_t             r_out
);
  import prao_pkg::*;

  localparam angle_t STEP = angle_t'(ATAN_TURNS[STAGE]);

  logic signed [WORK_WIDTH-1:0] xs, ys;
  logic                         up;

  always_comb begin
    xs = x_in >>> STAGE;
    ys = y_in >>> STAGE;
    up = ~r_in[ANGLE_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= up ? (x_in - ys) : (x_in + ys);
      y_out <= up ? (y_in + xs) : (y_in - xs);
      r_out <= up ? (r_in - STEP) : (r_in + STEP);
    end
  end

endmodule

// ----- hdl/prao_finish.sv -----
// drop guard bits with rounding, add the centre back and saturate
// two register stages; uses prao_pkg
module prao_finish #(
  parameter int COORD_WIDTH = 32,
  parameter int WORK_WIDTH  = 43
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [WORK_WIDTH-1:0]  x,
  input  logic signed [WORK_WIDTH-1:0]  y,
  input  logic signed [COORD_WIDTH-1:0] centre_x,
  input  logic signed [COORD_WIDTH-1:0] centre_y,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] rotated_x,
  output logic signed [COORD_WIDTH-1:0] rotated_y,
  output logic                          saturated
);
  import prao_pkg::*;

  localparam int RW = WORK_WIDTH - GUARD_BITS;
  localparam int SW = RW + 1;
  localparam logic signed [WORK_WIDTH-1:0] HALF = WORK_WIDTH'(1) << (GUARD_BITS - 1);
  localparam logic signed [COORD_WIDTH-1:0] MAX_C = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] MIN_C = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

  logic                  vld1;
  logic signed [RW-1:0]  rx, ry;

  logic signed [WORK_WIDTH-1:0] bx, by;
  logic signed [SW-1:0]         sx, sy;
  logic                         clip_x, clip_y;

  always_comb begin
    bx = x + HALF;
    by = y + HALF;
    sx = SW'(rx) + SW'(centre_x);
    sy = SW'(ry) + SW'(centre_y);
    // out of range when the bits above the coordinate sign disagree
    clip_x = (sx[SW-1:COORD_WIDTH-1] != {(SW - COORD_WIDTH + 1){sx[SW-1]}});
    clip_y = (sy[SW-1:COORD_WIDTH-1] != {(SW - COORD_WIDTH + 1){sy[SW-1]}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld1      <= in_valid;
      out_valid <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx        <= bx[WORK_WIDTH-1:GUARD_BITS];
      ry        <= by[WORK_WIDTH-1:GUARD_BITS];
      rotated_x <= clip_x ? (sx[SW-1] ? MIN_C : MAX_C) : sx[COORD_WIDTH-1:0];
      rotated_y <= clip_y ? (sy[SW-1] ? MIN_C : MAX_C) : sy[COORD_WIDTH-1:0];
      saturated <= clip_x | clip_y;
    end
  end

endmodule

// ----- hdl/point_rotation_about_origin.sv -----
// top level of the point rotation block: config registers, cordic cell chain
// and output skid stage; uses prao_pkg, prao_prescale, prao_cell, prao_finish
//
// rotates each input point about the configured centre by turn_angle (2^32 is
// a full turn), clockwise when the clockwise register is set. one point is
// taken per clock while the skid stage is empty, and one result is delivered
// per point, in order. each point passes the offset, gain prescale and quarter
// turn, then each cordic cell, then rounding and saturation and the output
// register. the chain of cells advances as one; it only holds while the skid
// stage is full, so a waiting result does not block the input. there is no
// clearing pass after reset. configuration writes take effect at once and
// should be made while no point is in flight.
module point_rotation_about_origin #(
  parameter int COORD_WIDTH     = 32,
  parameter int ROTATION_STAGES = 24
) (
  input  logic clk,
  input  logic rst,
  // point_x, point_y from bit 0 up
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  logic [((2 * COORD_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
  // rotated_x, rotated_y, saturated from bit 0 up
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  output logic [((2 * COORD_WIDTH + 8) / 8) * 8-1:0] m_axis_tdata,
  // configuration write port
  input  logic                                                  cfg_we,
  input  prao_pkg::reg_index_t                                  cfg_index,
  input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0]    cfg_data
);
  import prao_pkg::*;

  localparam int WORK_WIDTH = COORD_WIDTH + GUARD_BITS + 3;
  localparam int OUT_BITS   = ((2 * COORD_WIDTH + 8) / 8) * 8;
  localparam logic [ANGLE_W-1:0] EIGHTH = ANGLE_W'(1) << (ANGLE_W - 3);

  // configuration registers
  logic signed [COORD_WIDTH-1:0] centre_x, centre_y;
  logic [ANGLE_W-1:0]            turn_angle;
  logic                          clockwise;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x   <= '0;
      centre_y   <= '0;
      turn_angle <= '0;
      clockwise  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTRE_X:  centre_x   <= cfg_data[COORD_WIDTH-1:0];
        REG_CENTRE_Y:  centre_y   <= cfg_data[COORD_WIDTH-1:0];
        REG_TURN:      turn_angle <= cfg_data[ANGLE_W-1:0];
        REG_CLOCKWISE: clockwise  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // angle split into a quarter turn and a residue in [-1/8, 1/8) turn,
  // registered once since it only follows the configuration
  logic [ANGLE_W-1:0] ang, ang_bias;
  quad_t              quad, quad_next;
  angle_t             r0, r0_next;

  always_comb begin
    ang       = clockwise ? (ANGLE_W'(0) - turn_angle) : turn_angle;
    ang_bias  = ang + EIGHTH;
    quad_next = ang_bias[ANGLE_W-1:ANGLE_W-2];
    r0_next   = angle_t'(ang - {quad_next, {(ANGLE_W - 2){1'b0}}});
  end

  always_ff @(posedge clk) begin
    quad <= quad_next;
    r0   <= r0_next;
  end

  // whole pipeline moves whenever the skid stage is empty
  logic en;
  logic skid_valid;

  assign en            = ~skid_valid;
  assign s_axis_tready = en;

  // offset, prescale and quarter turn
  logic                         pre_valid;
  logic signed [WORK_WIDTH-1:0] pre_x, pre_y;

  prao_prescale #(
    .COORD_WIDTH (COORD_WIDTH),
    .WORK_WIDTH  (WORK_WIDTH)
  ) u_prescale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .point_x   (s_axis_tdata[COORD_WIDTH-1:0]),
    .point_y   (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .centre_x  (centre_x),
    .centre_y  (centre_y),
    .quad      (quad),
    .out_valid (pre_valid),
    .x         (pre_x),
    .y         (pre_y)
  );

  // chain of micro-rotation cells, each hands x, y and residue angle on
  logic                         cv [0:ROTATION_STAGES];
  logic signed [WORK_WIDTH-1:0] cx [0:ROTATION_STAGES];
  logic signed [WORK_WIDTH-1:0] cy [0:ROTATION_STAGES];
  angle_t                       cr [0:ROTATION_STAGES];

  assign cv[0] = pre_valid;
  assign cx[0] = pre_x;
  assign cy[0] = pre_y;
  assign cr[0] = r0;

  for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_cell
    prao_cell #(
      .WORK_WIDTH (WORK_WIDTH),
      .STAGE      (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cv[g]),
      .x_in      (cx[g]),
      .y_in      (cy[g]),
      .r_in      (cr[g]),
      .out_valid (cv[g+1]),
      .x_out     (cx[g+1]),
      .y_out     (cy[g+1]),
      .r_out     (cr[g+1])
    );
  end

  // rounding, centre add-back, saturation
  logic                          fin_valid;
  logic signed [COORD_WIDTH-1:0] fin_x, fin_y;
  logic                          fin_sat;

  prao_finish #(
    .COORD_WIDTH (COORD_WIDTH),
    .WORK_WIDTH  (WORK_WIDTH)
  ) u_finish (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cv[ROTATION_STAGES]),
    .x         (cx[ROTATION_STAGES]),
    .y         (cy[ROTATION_STAGES]),
    .centre_x  (centre_x),
    .centre_y  (centre_y),
    .out_valid (fin_valid),
    .rotated_x (fin_x),
    .rotated_y (fin_y),
    .saturated (fin_sat)
  );

  // output register plus one-word skid stage
  logic [2*COORD_WIDTH:0] fin_word, skid_word, out_word;
  logic                   out_free, push;

  assign fin_word = {fin_sat, fin_y, fin_x};
  assign out_free = ~m_axis_tvalid | m_axis_tready;
  assign push     = en & fin_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (out_free) begin
      // skid word goes first; while it is held no new word arrives
      m_axis_tvalid <= skid_valid | push;
      skid_valid    <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_word <= skid_valid ? skid_word : fin_word;
    end else if (push) begin
      skid_word <= fin_word;
    end
  end

  // zero fill above the saturated flag
  assign m_axis_tdata = OUT_BITS'(out_word);

endmodule

// ----- sim/point_rotation_about_origin_checker.sv -----
// checker for point_rotation_about_origin: watches the stream and config ports,
// predicts each rotated point on its own and compares results in order
// depends on prao_pkg for the register index type and names
module point_rotation_about_origin_checker #(
  parameter int COORD_WIDTH     = 32,
  parameter int ROTATION_STAGES = 24
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_tvalid,
  input  logic                                        s_tready,
  input  logic [((2 * COORD_WIDTH + 7) / 8) * 8-1:0]  s_tdata,
  input  logic                                        m_tvalid,
  input  logic                                        m_tready,
  input  logic [((2 * COORD_WIDTH + 8) / 8) * 8-1:0]  m_tdata,
  input  logic                                        cfg_we,
  input  prao_pkg::reg_index_t                        cfg_index,
  input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] cfg_data,
  output int                                          pending,
  output int                                          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import prao_pkg::*;

  localparam int          CW        = COORD_WIDTH;
  localparam int          FRAC_EXT  = 8;
  localparam int          ATAN_LEN  = 32;
  localparam logic [31:0] GAIN_Q32  = 32'd2608131496;

  localparam longint ATAN_STEP [ATAN_LEN] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          sat;
  } rotated_point_t;

  logic signed [CW-1:0] centre_x;
  logic signed [CW-1:0] centre_y;
  logic [31:0]          turn_angle;
  logic                 clockwise;

  rotated_point_t expected_points [$];
  int             result_index;

  // offset times inverse gain, with extra fraction bits, rounded half up on magnitude
  function automatic longint gain_scale(longint d);
    logic [63:0]  mag;
    logic [103:0] prod;
    longint       v;
    mag  = (d < 0) ? -d : d;
    prod = ({40'b0, mag} << FRAC_EXT) * GAIN_Q32 + 104'h8000_0000;
    v    = prod[95:32];
    return (d < 0) ? -v : v;
  endfunction

  function automatic longint round_and_clip(longint w, longint c, inout bit clip);
    longint hi, lo, s;
    hi = (64'sd1 <<< (CW - 1)) - 1;
    lo = -hi - 1;
    s  = ((w + (64'sd1 <<< (FRAC_EXT - 1))) >>> FRAC_EXT) + c;
    if (s > hi) begin
      clip = 1'b1;
      return hi;
    end
    if (s < lo) begin
      clip = 1'b1;
      return lo;
    end
    return s;
  endfunction

  function automatic rotated_point_t rotate_point(logic signed [CW-1:0] px,
                                                  logic signed [CW-1:0] py);
    longint             cx, cy, x, y, t, xs, ys, r, fx, fy;
    logic [31:0]        a, a_round;
    logic [1:0]         q;
    logic signed [31:0] r_word;
    bit                 clip;
    rotated_point_t     res;
    cx = longint'(centre_x);
    cy = longint'(centre_y);
    x  = gain_scale(longint'(px) - cx);
    y  = gain_scale(longint'(py) - cy);
    a       = clockwise ? (32'd0 - turn_angle) : turn_angle;
    a_round = a + 32'h2000_0000;
    q       = a_round[31:30];
    r_word  = a - {q, 30'b0};
    r       = longint'(r_word);
    // coarse quarter turn, exact
    case (q)
      2'd1: begin
        t = x; x = -y; y = t;
      end
      2'd2: begin
        x = -x; y = -y;
      end
      2'd3: begin
        t = x; x = y; y = -t;
      end
      default: ;
    endcase
    for (int i = 0; i < ROTATION_STAGES && i < ATAN_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (r >= 0) begin
        x = x - ys; y = y + xs; r = r - ATAN_STEP[i];
      end else begin
        x = x + ys; y = y - xs; r = r + ATAN_STEP[i];
      end
    end
    clip    = 1'b0;
    fx      = round_and_clip(x, cx, clip);
    fy      = round_and_clip(y, cy, clip);
    res.x   = fx[CW-1:0];
    res.y   = fy[CW-1:0];
    res.sat = clip;
    return res;
  endfunction

  always @(posedge clk) begin
    rotated_point_t want, got;
    if (rst) begin
      centre_x     = '0;
      centre_y     = '0;
      turn_angle   = '0;
      clockwise    = 1'b1;
      result_index = 0;
      expected_points.delete();
      pending    <= 0;
      mismatches <= 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_points.push_back(rotate_point(s_tdata[CW-1:0], s_tdata[2*CW-1:CW]));
      if (m_tvalid && m_tready) begin
        got.x   = m_tdata[CW-1:0];
        got.y   = m_tdata[2*CW-1:CW];
        got.sat = m_tdata[2*CW];
        if (expected_points.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d arrived with nothing expected: x=%h y=%h sat=%b",
                     result_index, got.x, got.y, got.sat);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_points.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("result %0d: expected x=%h y=%h sat=%b, got x=%h y=%h sat=%b",
                       result_index, want.x, want.y, want.sat, got.x, got.y, got.sat);
            mismatches <= mismatches + 1;
          end
        end
        result_index++;
      end
      // register writes land after any point taken on the same edge
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTRE_X:  centre_x   = cfg_data[CW-1:0];
          REG_CENTRE_Y:  centre_y   = cfg_data[CW-1:0];
          REG_TURN:      turn_angle = cfg_data[31:0];
          REG_CLOCKWISE: clockwise  = cfg_data[0];
          default: ;
        endcase
      end
      pending <= expected_points.size();
    end
  end

endmodule

// ----- sim/point_rotation_about_origin_tb.sv -----
// top of the point rotation testbench: clock, reset, stimulus and verdict
// depends on prao_pkg, point_rotation_about_origin and the checker module
module point_rotation_about_origin_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prao_pkg::*;

  localparam int CW     = 32;
  localparam int STAGES = 24;
  localparam int IN_W   = ((2 * CW + 7) / 8) * 8;
  localparam int OUT_W  = ((2 * CW + 8) / 8) * 8;
  localparam int CFG_W  = (CW > 32) ? CW : 32;
  // input to output latency plus margin, for the drain at the end
  localparam int DRAIN_CYCLES = STAGES + 8 + 16;
  // cycles without any word moving before the run is declared hung
  localparam int HANG_LIMIT   = 5000;
  localparam int SEGMENTS     = 9;
  localparam int SEGMENT_LEN  = 50;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;   // point_x, point_y from bit 0 up
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;        // rotated_x, rotated_y, saturated from bit 0 up
  logic             cfg_we = 1'b0;
  reg_index_t       cfg_index = REG_CENTRE_X;
  logic [CFG_W-1:0] cfg_data = '0;

  int pending;
  int mismatches;
  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;
  int quiet_cycles    = 0;

  point_rotation_about_origin #(
    .COORD_WIDTH     (CW),
    .ROTATION_STAGES (STAGES)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  point_rotation_about_origin_checker #(
    .COORD_WIDTH     (CW),
    .ROTATION_STAGES (STAGES)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_axis_tvalid),
    .s_tready   (s_axis_tready),
    .s_tdata    (s_axis_tdata),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .mismatches (mismatches)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // receiver side: stall at random with the current phase's rate
  always @(posedge clk) begin
    if (rst)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // hang watchdog: any moving word or register write restarts the count
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("point_rotation_about_origin test failed");
      $finish;
    end
  end

  // one point word; valid stays up into the next word unless a gap is drawn
  task automatic send_point(logic [CW-1:0] px, logic [CW-1:0] py);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({py, px});
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // drop valid and wait until every predicted point has come out
  task automatic drain_points();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // all four registers, only with the pipe empty
  task automatic set_rotation(logic [CW-1:0] cx, logic [CW-1:0] cy,
                              logic [31:0] turn, logic cw);
    logic [CFG_W-1:0] cw_word;
    drain_points();
    cw_word    = CFG_W'($urandom());
    cw_word[0] = cw;            // upper bits are noise the block must ignore
    write_reg(REG_CENTRE_X, CFG_W'(cx));
    write_reg(REG_CENTRE_Y, CFG_W'(cy));
    write_reg(REG_TURN, CFG_W'(turn));
    write_reg(REG_CLOCKWISE, cw_word);
    cfg_we <= 1'b0;
  endtask

  // mix of full range, small, mid and extreme coordinates
  function automatic logic [CW-1:0] pick_coord();
    logic [CW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = CW'($urandom());
      4, 5, 6, 7: v = CW'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
      8: begin
        case ($urandom_range(0, 3))
          0: v = {1'b0, {(CW-1){1'b1}}};
          1: v = {1'b1, {(CW-1){1'b0}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = CW'(int'($urandom_range(0, 2 ** 25)) - 2 ** 24);
    endcase
    return v;
  endfunction

  localparam logic [CW-1:0] MAX_C = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MIN_C = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] ONE_C = CW'(32'h0001_0000);

  initial begin
    logic [CW-1:0] cx, cy;
    logic [31:0]   turn;
    logic          cw;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero centre, zero angle, so only gain rounding shows
    send_point('0, '0);
    send_point(ONE_C, '0);
    send_point(MAX_C, MAX_C);
    send_point(MIN_C, MIN_C);
    send_point(MAX_C, MIN_C);
    send_point('1, CW'(1));

    // extreme centre and half turn: offsets that need the extra bit, clipping
    set_rotation(MAX_C, MIN_C, 32'h8000_0000, 1'b1);
    send_point(MIN_C, MAX_C);
    send_point(MAX_C, MIN_C);
    send_point('0, '0);
    send_point(MIN_C, MIN_C);

    // counterclockwise quarter turn about the origin
    set_rotation('0, '0, 32'h4000_0000, 1'b0);
    send_point(ONE_C, '0);
    send_point('0, ONE_C);
    send_point(MAX_C, '0);
    send_point(MIN_C, '0);

    // clockwise three quarters, off-origin centre
    set_rotation(ONE_C, -ONE_C, 32'hC000_0000, 1'b1);
    send_point('0, '0);
    send_point(ONE_C, ONE_C);
    send_point(-ONE_C, MAX_C);

    // angles right on and just off the quarter rounding edge
    set_rotation('0, '0, 32'h2000_0000, 1'b1);
    send_point(ONE_C, ONE_C);
    send_point(-ONE_C, ONE_C);
    set_rotation('0, '0, 32'h1FFF_FFFF, 1'b0);
    send_point(ONE_C, -ONE_C);
    send_point(CW'(32'h0123_4567), CW'(32'hFEDC_BA98));

    // random segments, each with its own settings and idling phase
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin
          cx = '0; cy = '0; turn = 32'h2000_0000; cw = 1'b0;
        end
        1: begin
          cx = MAX_C; cy = MIN_C; turn = 32'hFFFF_FFFF; cw = 1'b1;
        end
        2: begin
          cx = MIN_C; cy = MAX_C; turn = 32'h1FFF_FFFF; cw = 1'b0;
        end
        3: begin
          cx = '0; cy = '0; turn = '0; cw = 1'b0;
        end
        4: begin
          cx = CW'($urandom()); cy = CW'($urandom()); turn = 32'h8000_0000; cw = 1'b1;
        end
        default: begin
          cx   = ($urandom_range(0, 1) != 0) ? pick_coord() : CW'($urandom());
          cy   = ($urandom_range(0, 1) != 0) ? pick_coord() : CW'($urandom());
          turn = $urandom();
          cw   = 1'($urandom_range(0, 1));
        end
      endcase
      set_rotation(cx, cy, turn, cw);
      case (seg % 4)
        0: begin
          sender_idle_pct = 0;  sink_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 77; sink_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;  sink_stall_pct = 77;
        end
        default: begin
          sender_idle_pct = 15; sink_stall_pct = 15;
        end
      endcase
      for (int n = 0; n < SEGMENT_LEN; n++)
        send_point(pick_coord(), pick_coord());
    end

    // wait out every prediction, then the pipe depth for strays
    drain_points();
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("point_rotation_about_origin test passed");
    else
      $display("point_rotation_about_origin test failed");
    $finish;
  end

endmodule
